/* src/pcg32_dice_roller_defines.svh */
// Assertion macros for the PCG32 die roller.
`ifndef PCG32_DICE_ROLLER_DEFINES_SVH
`define PCG32_DICE_ROLLER_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define PCGDR_ASSERT_AT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define PCGDR_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`else

`define PCGDR_ASSERT_AT(lbl, prop, msg)
`define PCGDR_ASSERT_NEXT(lbl, trig, cons, msg)

`endif

`endif

/* src/pcgdr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the PCG32 die roller.
package pcgdr_pkg;

    localparam logic [63:0] LCG_MULT = 64'h5851_F42D_4C95_7F2D;

    // XSH-RR output permutation
    localparam int XSH_SHIFT = 18;
    localparam int XSH_DROP  = 27;
    localparam int ROT_SHIFT = 59;
    localparam int ROT_W     = 5;

    localparam int DRAW_W  = 32;
    localparam int SIDES_W = 16;
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 9;

    typedef enum logic [1:0] {
        MODE_ROLL,
        MODE_RAW,
        MODE_LOAD,
        MODE_RESTART
    } t_mode;

    typedef enum logic [1:0] {
        CFG_RNG_MODE,
        CFG_SEED,
        CFG_STREAM,
        CFG_SCRIPT_LEN
    } t_cfg_index;

    typedef enum logic [1:0] {
        LCG_STEP,
        LCG_RESEED,
        LCG_ADD_SEED
    } t_lcg_op;

    typedef struct packed {
        logic    go;
        t_lcg_op op;
    } t_lcg_req;

    typedef struct packed {
        logic              done;
        logic [DRAW_W-1:0] draw;
    } t_lcg_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCRIPT,
        S_THRESH,
        S_DRAW,
        S_MOD,
        S_RAW,
        S_RST_SEED,
        S_RST_STEP1,
        S_RST_ADD,
        S_RST_STEP2,
        S_EMIT
    } t_state;

endpackage

/* src/pcgdr_lcg.sv */
`timescale 1ns / 1ps
// PCG32 generator: 64-bit LCG stepped on one shared 32x32 multiplier.
module pcgdr_lcg
    import pcgdr_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_lcg_req       i_req,
    input  logic [63:0]    i_seed,
    input  logic [62:0]    i_stream,
    output t_lcg_rsp       o_rsp
);

    localparam logic [2:0] PH_LAST = 3'd4;

    logic [63:0]       r_state, n_state;
    logic [63:0]       r_inc, n_inc;
    logic [63:0]       r_prod, n_prod;
    logic [63:0]       r_acc, n_acc;
    logic [2:0]        r_phase, n_phase;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DRAW_W-1:0] r_draw, n_draw;

    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [63:0]       mul_p;

    // XSH-RR permutation of the old state
    function automatic logic [DRAW_W-1:0] xsh_rr(input logic [63:0] old);
        logic [63:0]       mixed;
        logic [DRAW_W-1:0] xs;
        logic [ROT_W-1:0]  rot;
        logic [63:0]       twice;
        mixed = ((old >> XSH_SHIFT) ^ old) >> XSH_DROP;
        xs    = mixed[DRAW_W-1:0];
        rot   = old[ROT_SHIFT +: ROT_W];
        twice = {xs, xs} >> rot;
        return twice[DRAW_W-1:0];
    endfunction

    // pick the partial product for this phase
    always_comb begin
        mul_a = (r_phase == 3'd2) ? r_state[63:32] : r_state[31:0];
        mul_b = (r_phase == 3'd1) ? LCG_MULT[63:32] : LCG_MULT[31:0];
    end

    assign mul_p = mul_a * mul_b;

    // sequence the multiply-add and the reseed and seed-add commands
    always_comb begin
        n_state = r_state;
        n_inc   = r_inc;
        n_prod  = r_prod;
        n_acc   = r_acc;
        n_phase = r_phase;
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_draw  = r_draw;
        if (r_busy) begin
            n_phase = r_phase + 3'd1;
            case (r_phase)
                3'd0: begin
                    n_prod = mul_p;
                end
                3'd1: begin
                    n_acc  = r_prod;
                    n_prod = mul_p;
                end
                3'd2: begin
                    n_acc[63:32] = r_acc[63:32] + r_prod[31:0];
                    n_prod       = mul_p;
                end
                3'd3: begin
                    n_acc[63:32] = r_acc[63:32] + r_prod[31:0];
                end
                default: begin
                    n_state = r_acc + r_inc;
                    n_busy  = 1'b0;
                    n_done  = 1'b1;
                end
            endcase
            if (r_phase == PH_LAST) begin
                n_phase = '0;
            end
        end else if (i_req.go) begin
            case (i_req.op)
                LCG_STEP: begin
                    n_draw  = xsh_rr(r_state);
                    n_busy  = 1'b1;
                    n_phase = '0;
                end
                LCG_RESEED: begin
                    n_state = '0;
                    n_inc   = {i_stream, 1'b1};
                    n_done  = 1'b1;
                end
                LCG_ADD_SEED: begin
                    n_state = r_state + i_seed;
                    n_done  = 1'b1;
                end
                default: begin
                    n_done = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_inc   <= 64'd1;
            r_phase <= '0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_inc   <= n_inc;
            r_phase <= n_phase;
            r_busy  <= n_busy;
            r_done  <= n_done;
        end
    end

    // datapath holds need no reset
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_acc  <= n_acc;
        r_draw <= n_draw;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.draw = r_draw;

endmodule

/* src/pcgdr_mod.sv */
`timescale 1ns / 1ps
// Bit-serial remainder unit: 32-bit dividend modulo a 16-bit divisor.
module pcgdr_mod
    import pcgdr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DRAW_W-1:0]  i_dividend,
    input  logic [SIDES_W-1:0] i_divisor,
    output logic               o_done,
    output logic [SIDES_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(DRAW_W);

    logic [DRAW_W-1:0]  r_dvd, n_dvd;
    logic [SIDES_W-1:0] r_div, n_div;
    logic [SIDES_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_busy, n_busy;
    logic               r_done, n_done;

    logic [SIDES_W:0]   trial;
    logic [SIDES_W:0]   diff;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_dvd[DRAW_W-1]};
        diff  = trial - {1'b0, r_div};
    end

    always_comb begin
        n_dvd   = r_dvd;
        n_div   = r_div;
        n_rem   = r_rem;
        n_count = r_count;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (r_busy) begin
            n_dvd   = {r_dvd[DRAW_W-2:0], 1'b0};
            n_rem   = diff[SIDES_W] ? trial[SIDES_W-1:0] : diff[SIDES_W-1:0];
            n_count = r_count - 1'b1;
            if (r_count == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_start) begin
            n_dvd   = i_dividend;
            n_div   = i_divisor;
            n_rem   = '0;
            n_count = CNT_W'(DRAW_W - 1);
            n_busy  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* src/pcg32_dice_roller.sv */
`timescale 1ns / 1ps
// PCG32 die roller. One beat in on the slave stream, one result beat out.
// Input beat: tuser holds the mode (roll, raw draw, load script byte,
// restart); tdata holds sides, script index and script byte. Output beat:
// tdata holds the 32-bit value, tuser the sticky error flag.
// Configuration registers (rng mode, seed, stream, script length) are written
// through the plain write port while the block is idle; the user must keep to this, the block leaves it unchecked.
// One item is worked at a time; o_s_axis_tready is high only between items.
// The roll time is set by the bit-serial remainder unit (two 32-step passes:
// rejection threshold, then the draw modulo sides) and by the multiply
// sequence of the shared 32x32 multiplier in the generator.
// The output register holds a finished beat until it is taken; the next item
// is accepted meanwhile, and its result waits in the sequencer if the
// receiver still stalls. Reset clears the generator (state 0, increment 1),
// the script position, the error flag and the registers; the script store
// keeps no reset and must be loaded before it is replayed.
`include "pcg32_dice_roller_defines.svh"
module pcg32_dice_roller
    import pcgdr_pkg::*;
#(
    parameter int SCRIPT_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // sides[15:0], script_index[23:16], script_byte[31:24]
    input  logic [1:0]  i_s_axis_tuser,  // mode[1:0]
    // master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // value[31:0]
    output logic        o_m_axis_tuser,  // error[0]
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata
);

    localparam int AW = (SCRIPT_DEPTH > 1) ? $clog2(SCRIPT_DEPTH) : 1;
    localparam logic [16:0] DEPTH_W = 17'(SCRIPT_DEPTH);

    // configuration
    logic              r_rng_mode;
    logic [63:0]       r_seed;
    logic [62:0]       r_stream;
    logic [POS_W-1:0]  r_replay_len;

    // sequencer and working state
    t_state             r_state, n_state;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic               r_error, n_error;
    logic [DRAW_W-1:0]  r_value, n_value;
    logic [SIDES_W-1:0] r_sides, n_sides;
    logic [SIDES_W-1:0] r_thresh, n_thresh;

    // output register
    logic              r_out_valid;
    logic [DRAW_W-1:0] r_out_value;
    logic              r_out_error;

    // script store
    logic [BYTE_W-1:0] r_script_mem [SCRIPT_DEPTH];
    logic [BYTE_W-1:0] r_script_rd;

    // decoded input beat
    logic               in_acc;
    t_mode              in_mode;
    logic [SIDES_W-1:0] in_sides;
    logic [BYTE_W-1:0]  in_idx;
    logic [BYTE_W-1:0]  in_byte;

    logic [16:0]        eff_len;
    logic               script_empty;
    logic               load_in_range;
    logic               byte_bad;
    logic               out_free;
    logic               draw_ok;

    // control to the shared units
    t_lcg_req           lcg_req;
    t_lcg_rsp           lcg_rsp;
    logic               mod_start;
    logic [DRAW_W-1:0]  mod_dividend;
    logic [SIDES_W-1:0] mod_divisor;
    logic               mod_done;
    logic [SIDES_W-1:0] mod_rem;
    logic               mem_wr;
    logic               mem_rd;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc   = i_s_axis_tvalid & o_s_axis_tready;
    assign in_mode  = t_mode'(i_s_axis_tuser);
    assign in_sides = i_s_axis_tdata[15:0];
    assign in_idx   = i_s_axis_tdata[23:16];
    assign in_byte  = i_s_axis_tdata[31:24];

    // replay limits and checks
    always_comb begin
        eff_len       = ({8'b0, r_replay_len} > DEPTH_W) ? DEPTH_W : {8'b0, r_replay_len};
        script_empty  = ({8'b0, r_pos} >= eff_len);
        load_in_range = ({9'b0, in_idx} < DEPTH_W);
        byte_bad      = (r_script_rd == '0) || ({8'b0, r_script_rd} > r_sides);
        out_free      = !r_out_valid || i_m_axis_tready;
        draw_ok       = (lcg_rsp.draw >= {16'b0, r_thresh});
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (in_mode)
                        MODE_ROLL: begin
                            if (r_rng_mode) begin
                                n_state = script_empty ? S_EMIT : S_SCRIPT;
                            end else begin
                                n_state = (in_sides == '0) ? S_EMIT : S_THRESH;
                            end
                        end
                        MODE_RAW:     n_state = S_RAW;
                        MODE_LOAD:    n_state = S_EMIT;
                        MODE_RESTART: n_state = S_RST_SEED;
                        default:      n_state = S_EMIT;
                    endcase
                end
            end
            S_SCRIPT: n_state = S_EMIT;
            S_THRESH: begin
                if (mod_done) n_state = S_DRAW;
            end
            S_DRAW: begin
                if (lcg_rsp.done && draw_ok) n_state = S_MOD;
            end
            S_MOD: begin
                if (mod_done) n_state = S_EMIT;
            end
            S_RAW: begin
                if (lcg_rsp.done) n_state = S_EMIT;
            end
            S_RST_SEED: begin
                if (lcg_rsp.done) n_state = S_RST_STEP1;
            end
            S_RST_STEP1: begin
                if (lcg_rsp.done) n_state = S_RST_ADD;
            end
            S_RST_ADD: begin
                if (lcg_rsp.done) n_state = S_RST_STEP2;
            end
            S_RST_STEP2: begin
                if (lcg_rsp.done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // unit commands and store access
    always_comb begin
        lcg_req.go   = 1'b0;
        lcg_req.op   = LCG_STEP;
        mod_start    = 1'b0;
        mod_dividend = lcg_rsp.draw;
        mod_divisor  = r_sides;
        mem_wr       = 1'b0;
        mem_rd       = 1'b0;
        case (r_state)
            S_IDLE: begin
                mod_dividend = DRAW_W'(0) - {16'b0, in_sides};
                mod_divisor  = in_sides;
                if (in_acc) begin
                    case (in_mode)
                        MODE_ROLL: begin
                            mem_rd    = r_rng_mode && !script_empty;
                            mod_start = !r_rng_mode && (in_sides != '0);
                        end
                        MODE_RAW: begin
                            lcg_req.go = 1'b1;
                        end
                        MODE_LOAD: begin
                            mem_wr = load_in_range;
                        end
                        MODE_RESTART: begin
                            lcg_req.go = 1'b1;
                            lcg_req.op = LCG_RESEED;
                        end
                        default: ;
                    endcase
                end
            end
            S_THRESH: begin
                lcg_req.go = mod_done;
            end
            S_DRAW: begin
                lcg_req.go = lcg_rsp.done && !draw_ok;
                mod_start  = lcg_rsp.done && draw_ok;
            end
            S_RST_SEED: begin
                lcg_req.go = lcg_rsp.done;
            end
            S_RST_STEP1: begin
                lcg_req.go = lcg_rsp.done;
                lcg_req.op = LCG_ADD_SEED;
            end
            S_RST_ADD: begin
                lcg_req.go = lcg_rsp.done;
            end
            default: ;
        endcase
    end

    // working registers
    always_comb begin
        n_pos    = r_pos;
        n_error  = r_error;
        n_value  = r_value;
        n_sides  = r_sides;
        n_thresh = r_thresh;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_sides = in_sides;
                    n_value = (in_mode == MODE_ROLL) ? DRAW_W'(1) : '0;
                    if (in_mode == MODE_ROLL) begin
                        if (r_rng_mode) begin
                            if (script_empty) n_error = 1'b1;
                            else n_pos = r_pos + 1'b1;
                        end else if (in_sides == '0) begin
                            n_error = 1'b1;
                        end
                    end
                    if (in_mode == MODE_RESTART) begin
                        n_error = 1'b0;
                        n_pos   = '0;
                    end
                end
            end
            S_SCRIPT: begin
                if (byte_bad) n_error = 1'b1;
                else n_value = {24'b0, r_script_rd};
            end
            S_THRESH: begin
                if (mod_done) n_thresh = mod_rem;
            end
            S_MOD: begin
                if (mod_done) n_value = {16'b0, mod_rem} + DRAW_W'(1);
            end
            S_RAW: begin
                if (lcg_rsp.done) n_value = lcg_rsp.draw;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_error <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_error <= n_error;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_sides  <= n_sides;
        r_thresh <= n_thresh;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rng_mode   <= 1'b0;
            r_seed       <= '0;
            r_stream     <= '0;
            r_replay_len <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_RNG_MODE:   r_rng_mode   <= i_cfg_wdata[0];
                CFG_SEED:       r_seed       <= i_cfg_wdata;
                CFG_STREAM:     r_stream     <= i_cfg_wdata[62:0];
                CFG_SCRIPT_LEN: r_replay_len <= i_cfg_wdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // script store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_script_mem[AW'(in_idx)] <= in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_rd) begin
            r_script_rd <= r_script_mem[AW'(r_pos)];
        end
    end

    // output register: load a finished beat, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_out_value <= r_value;
            r_out_error <= r_error;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = r_out_error;

    pcgdr_lcg u_lcg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (lcg_req),
        .i_seed   (r_seed),
        .i_stream (r_stream),
        .o_rsp    (lcg_rsp)
    );

    pcgdr_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dividend),
        .i_divisor  (mod_divisor),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // no unit reports completion while the sequencer waits for a new beat
    `PCGDR_ASSERT_AT(a_idle_quiet, (r_state != S_IDLE) || (!lcg_rsp.done && !mod_done), "unit done while idle")

    // a draw goes to the remainder unit only at or above the rejection threshold
    `PCGDR_ASSERT_AT(a_draw_accepted, !(r_state == S_DRAW && mod_start) || draw_ok, "rejected draw used")

    // a stalled output beat is never overwritten
    `PCGDR_ASSERT_NEXT(a_emit_holds, (r_state == S_EMIT) && r_out_valid && !i_m_axis_tready, (r_state == S_EMIT) && r_out_valid, "result dropped on stall")

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Self-checking stream testbench for the PCG32 die roller, with a bit-true mirror of the block.
module tb
    import pcgdr_pkg::*;
();

    localparam int DEPTH           = 256;
    localparam int TOTAL_ITEMS     = 1100;
    localparam int QUIET_TAIL      = 150;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 100;

    typedef struct packed {
        logic [31:0] value;
        logic        err;
    } t_roll_out;

    // Mirror of the roller: generator, script store, sticky error and owed results
    class dice_mirror;
        logic        rng_mode;
        logic [63:0] seed;
        logic [62:0] stream;
        logic [8:0]  replay_len;
        logic [63:0] lcg_state;
        logic [63:0] lcg_inc;
        logic [7:0]  script_mem [DEPTH];
        logic [8:0]  replay_pos;
        logic        err_flag;
        t_roll_out   owed [$];
        int          mismatches;

        function new();
            rng_mode   = 1'b0;
            seed       = 64'd0;
            stream     = 63'd0;
            replay_len = 9'd0;
            lcg_state  = 64'd0;
            lcg_inc    = 64'd1;
            replay_pos = 9'd0;
            err_flag   = 1'b0;
            mismatches = 0;
            foreach (script_mem[k]) script_mem[k] = 8'd0;
        endfunction

        function void write_reg(t_cfg_index idx, logic [63:0] v);
            case (idx)
                CFG_RNG_MODE:   rng_mode   = v[0];
                CFG_SEED:       seed       = v;
                CFG_STREAM:     stream     = v[62:0];
                CFG_SCRIPT_LEN: replay_len = v[8:0];
                default: ;
            endcase
        endfunction

        // Advance the LCG and permute the old state into a 32-bit draw
        function logic [31:0] step_lcg();
            logic [63:0] prior;
            logic [63:0] mixed;
            logic [31:0] xs;
            logic [4:0]  rot;
            prior     = lcg_state;
            lcg_state = prior * LCG_MULT + lcg_inc;
            mixed     = ((prior >> XSH_SHIFT) ^ prior) >> XSH_DROP;
            xs        = mixed[31:0];
            rot       = prior[ROT_SHIFT +: ROT_W];
            return (xs >> rot) | (xs << ((32 - rot) & 31));
        endfunction

        function void reseed();
            lcg_state = 64'd0;
            lcg_inc   = {stream, 1'b1};
            void'(step_lcg());
            lcg_state = lcg_state + seed;
            void'(step_lcg());
            err_flag   = 1'b0;
            replay_pos = 9'd0;
        endfunction

        // Replay a script byte, or draw with rejection of the biased low range
        function logic [31:0] roll_face(logic [15:0] sides);
            logic [8:0]  usable;
            logic [7:0]  face;
            logic [31:0] span;
            logic [31:0] reject_below;
            logic [31:0] draw;
            if (rng_mode) begin
                usable = replay_len;
                if (usable > DEPTH) usable = 9'(DEPTH);
                if (replay_pos >= usable) begin
                    err_flag = 1'b1;
                    return 32'd1;
                end
                face       = script_mem[replay_pos[7:0]];
                replay_pos = replay_pos + 9'd1;
                if (face == 8'd0 || {8'd0, face} > sides) begin
                    err_flag = 1'b1;
                    return 32'd1;
                end
                return {24'd0, face};
            end
            if (sides == 16'd0) begin
                err_flag = 1'b1;
                return 32'd1;
            end
            span         = {16'd0, sides};
            reject_below = (32'd0 - span) % span;
            draw         = step_lcg();
            while (draw < reject_below) draw = step_lcg();
            return draw % span + 32'd1;
        endfunction

        function void accept_request(t_mode mode, logic [15:0] sides, logic [7:0] idx,
                                     logic [7:0] load_byte);
            t_roll_out res;
            res.value = 32'd0;
            case (mode)
                MODE_ROLL:    res.value = roll_face(sides);
                MODE_RAW:     res.value = step_lcg();
                MODE_LOAD:    script_mem[idx] = load_byte;
                MODE_RESTART: reseed();
                default: ;
            endcase
            res.err = err_flag;
            owed.push_back(res);
        endfunction

        function void match_output(logic [31:0] value, logic err);
            t_roll_out want;
            if (owed.size() == 0) begin
                $error("result beat with nothing owed: value %0h error %0b", value, err);
                mismatches++;
                return;
            end
            want = owed.pop_front();
            if (value !== want.value) begin
                $error("value: expected %0h, actual %0h", want.value, value);
                mismatches++;
            end
            if (err !== want.err) begin
                $error("error: expected %0b, actual %0b", want.err, err);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return owed.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;  // sides[15:0], script_index[23:16], script_byte[31:24]
    logic [1:0]  i_s_axis_tuser;  // mode[1:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;  // value[31:0]
    logic        o_m_axis_tuser;  // error[0]
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_wdata;

    dice_mirror mirror = new();
    int         items_sent   = 0;
    int         stall_cycles = 0;
    bit         quiet        = 1'b0;
    bit         src_idle_on  = 1'b0;
    bit         sink_idle_on = 1'b1;
    bit         hold_off_req = 1'b0;

    pcg32_dice_roller #(.SCRIPT_DEPTH(DEPTH)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Check result beats and stop the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            mirror.match_output(o_m_axis_tdata, o_m_axis_tuser);
        if (!i_rst_n || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_s_axis_tvalid && o_s_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request, none in the tail
    initial begin
        i_m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_m_axis_tready <= 1'b0;
                hold_off_req = 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
            end else if (!quiet && sink_idle_on && $urandom_range(0, 7) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Offer one beat, with an optional idle burst ahead of it, and hold until taken
    task automatic send_item(t_mode mode, logic [15:0] sides, logic [7:0] idx,
                             logic [7:0] load_byte);
        if (!quiet && src_idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {load_byte, idx, sides};
        i_s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        mirror.accept_request(mode, sides, idx, load_byte);
        items_sent++;
        quiet = (items_sent >= TOTAL_ITEMS - QUIET_TAIL);
    endtask

    task automatic cfg_write(t_cfg_index idx, logic [63:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        mirror.write_reg(idx, v);
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (mirror.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_sides();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 16'($urandom_range(1, 20));
        if (r < 88) return 16'($urandom_range(0, 65535));
        if (r < 96) begin
            case ($urandom_range(0, 3))
                0: return 16'd1;
                1: return 16'hFFFF;
                2: return 16'h8000;
                default: return 16'hFFFE;
            endcase
        end
        return 16'd0;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] rand_sides();
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic random_item(logic [15:0] roll_sides, int roll_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < roll_pct)
            send_item(MODE_ROLL, roll_sides, rand_byte(), rand_byte());
        else if (r < roll_pct + (100 - roll_pct) / 2)
            send_item(MODE_RAW, rand_sides(), rand_byte(), rand_byte());
        else if (r < 96)
            send_item(MODE_LOAD, rand_sides(), rand_byte(), rand_byte());
        else
            send_item(MODE_RESTART, rand_sides(), rand_byte(), rand_byte());
    endtask

    // Pseudorandom phase: reseed, then mostly rolls and raw draws
    task automatic run_prng_phase(int phase);
        logic [63:0] seed_v;
        logic [62:0] stream_v;
        int          n;
        case (phase)
            0: begin
                seed_v   = 64'd0;
                stream_v = 63'd0;
            end
            1: begin
                seed_v   = '1;
                stream_v = '1;
            end
            default: begin
                seed_v   = {$urandom, $urandom};
                stream_v = 63'({$urandom, $urandom});
            end
        endcase
        drain_results();
        cfg_write(CFG_RNG_MODE, 64'd0);
        cfg_write(CFG_SEED, seed_v);
        cfg_write(CFG_STREAM, {1'b0, stream_v});
        if (phase == 0)
            cfg_write(CFG_SCRIPT_LEN, 64'd0);
        else if ($urandom_range(0, 1) == 0)
            cfg_write(CFG_SCRIPT_LEN, 64'($urandom_range(0, DEPTH)));
        src_idle_on  = ($urandom_range(0, 3) != 0);
        sink_idle_on = ($urandom_range(0, 3) != 0);
        if (phase == 1) hold_off_req = 1'b1;
        send_item(MODE_RESTART, rand_sides(), rand_byte(), rand_byte());
        n = $urandom_range(40, 80);
        repeat (n) random_item(pick_sides(), 60);
    endtask

    // Script phase: fill the replayed range, restart, then mostly roll from the script
    task automatic run_script_phase(int nth);
        int         len;
        int         die;
        int         n;
        int         i;
        int         r;
        logic [7:0] b;
        case (nth)
            0:       len = DEPTH;
            1:       len = 0;
            default: len = $urandom_range(1, 24);
        endcase
        die = ($urandom_range(0, 3) == 0) ? $urandom_range(21, 255) : $urandom_range(1, 20);
        drain_results();
        cfg_write(CFG_RNG_MODE, 64'd1);
        cfg_write(CFG_SCRIPT_LEN, 64'(len));
        if (nth % 2 == 1) begin
            cfg_write(CFG_SEED, {$urandom, $urandom});
            cfg_write(CFG_STREAM, {1'b0, 63'({$urandom, $urandom})});
        end
        src_idle_on  = ($urandom_range(0, 3) != 0);
        sink_idle_on = ($urandom_range(0, 3) != 0);
        for (i = 0; i < len; i++) begin
            r = $urandom_range(0, 19);
            if (r < 15)      b = 8'($urandom_range(1, die));
            else if (r < 17) b = 8'd0;
            else             b = rand_byte();
            send_item(MODE_LOAD, rand_sides(), 8'(i), b);
        end
        send_item(MODE_RESTART, rand_sides(), rand_byte(), rand_byte());
        n = ((len < 30) ? len : 30) + $urandom_range(2, 6);
        repeat (n) random_item(($urandom_range(0, 9) == 0) ? pick_sides() : 16'(die), 80);
    endtask

    initial begin
        int phase;
        int script_no;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 32'd0;
        i_s_axis_tuser  = MODE_ROLL;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_RNG_MODE;
        i_cfg_wdata     = 64'd0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: die extremes, zero sides, raw draw, restart, store corners
        send_item(MODE_ROLL, 16'd1, 8'd0, 8'd0);
        send_item(MODE_ROLL, 16'd6, 8'd0, 8'd0);
        send_item(MODE_ROLL, 16'hFFFF, 8'd0, 8'd0);
        send_item(MODE_ROLL, 16'd0, 8'd0, 8'd0);
        send_item(MODE_RAW, 16'd0, 8'd0, 8'd0);
        send_item(MODE_RESTART, 16'd0, 8'd0, 8'd0);
        send_item(MODE_ROLL, 16'd2, 8'd0, 8'd0);
        send_item(MODE_RAW, 16'hFFFF, 8'hFF, 8'hFF);
        send_item(MODE_LOAD, 16'd0, 8'd0, 8'd1);
        send_item(MODE_LOAD, 16'd0, 8'd1, 8'd255);
        send_item(MODE_LOAD, 16'd0, 8'd2, 8'd6);
        send_item(MODE_LOAD, 16'd0, 8'd3, 8'd0);
        send_item(MODE_LOAD, 16'd0, 8'd255, 8'hAA);

        // Directed replay: in range, zero sides, byte zero, exhausted, raw in script mode
        drain_results();
        cfg_write(CFG_RNG_MODE, 64'd1);
        cfg_write(CFG_SCRIPT_LEN, 64'd4);
        send_item(MODE_RESTART, 16'd0, 8'd0, 8'd0);
        send_item(MODE_ROLL, 16'd6, 8'd0, 8'd0);
        send_item(MODE_ROLL, 16'd0, 8'd0, 8'd0);
        send_item(MODE_ROLL, 16'd6, 8'd0, 8'd0);
        send_item(MODE_ROLL, 16'hFFFF, 8'd0, 8'd0);
        send_item(MODE_ROLL, 16'd6, 8'd0, 8'd0);
        send_item(MODE_RAW, 16'd0, 8'd0, 8'd0);

        // Random phases: two pseudorandom phases, then one script replay phase, in turn
        phase     = 0;
        script_no = 0;
        while (items_sent < TOTAL_ITEMS) begin
            if (phase % 3 == 2) begin
                run_script_phase(script_no);
                script_no++;
            end else begin
                run_prng_phase(phase);
            end
            phase++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mirror.mismatches == 0 && mirror.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/pcgdr_pkg.sv
src/pcgdr_lcg.sv
src/pcgdr_mod.sv
src/pcg32_dice_roller.sv
test/tb.sv
